@@ hdl/bic_pkg.sv @@
package bic_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SEG_BITS  = 32;
  localparam int QW        = 32;
  localparam int DIV_BITS  = QW + FRAC_BITS;
  localparam int DIV_CW    = $clog2(DIV_BITS + 1);

  localparam logic [QW-1:0] WMAX = {QW{1'b1}};
  localparam logic [QW-1:0] QONE = QW'(1) << FRAC_BITS;
  // distance to the maximum that still counts as reaching it
  localparam logic [QW-1:0] DIFF_FLOOR = QW'((64'd1 << FRAC_BITS) / 64'd100000);

  localparam logic [2:0] REG_INIT_CWND     = 3'd0;
  localparam logic [2:0] REG_INIT_SSTHRESH = 3'd1;
  localparam logic [2:0] REG_BETA          = 3'd2;
  localparam logic [2:0] REG_LOW_SEGS      = 3'd3;
  localparam logic [2:0] REG_STEP_CAP      = 3'd4;
  localparam logic [2:0] REG_RESET_INIT    = 3'd5;
  localparam logic [2:0] REG_DISABLE_CWA   = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_APPLY,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_start;
    logic apply;
    logic mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_loss;
    logic react;
    logic need_div;
    logic div_done;
  } sts_t;

  typedef struct packed {
    logic [15:0] init_cwnd;
    logic [15:0] init_ssthresh;
    logic [15:0] beta;
    logic [15:0] low_segs;
    logic [15:0] step_cap;
    logic        reset_to_initial;
    logic        disable_cwa;
  } cfg_t;

  function automatic logic [QW-1:0] sat_q(input logic [QW:0] v);
    sat_q = v[QW] ? WMAX : v[QW-1:0];
  endfunction

  function automatic logic [QW-1:0] to_q(input logic [15:0] s);
    logic [QW+15:0] w;
    w = {{QW{1'b0}}, s} << FRAC_BITS;
    to_q = (w[QW+15:QW] != '0) ? WMAX : w[QW-1:0];
  endfunction

endpackage

@@ hdl/bic_congestion_window_top.sv @@
// channel | dir | tdata (low bit up)                         | tuser
// in      | in  | received_segment[31:0], highest_req[63:32] | action
// out     | out | window[31:0], threshold[63:32]             | loss_reacted
// cfg     | in  | cfg_index register, cfg_wdata[15:0] value   | none
// one item at a time; a divided increase runs the 48-step restoring divider,
// while a loss or a plain slow start step bypasses the divider
// synchronous active-low reset restores register defaults and window state
// the result sits in an output register; a stalled out channel holds the
// next item only once that register is full
module bic_congestion_window_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // received_segment, highest_requested
  input  logic        in_tuser,  // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // window, threshold
  output logic        out_tuser, // loss_reacted
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import bic_pkg::*;

  cfg_t  cfg_r;
  cmd_t  cmd;
  sts_t  sts;
  logic  busy, ov_r;
  logic [31:0] win, thr;
  logic  reacted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{16'd1, 16'hFFFF, 16'd52429, 16'd14, 16'd16, 1'b0, 1'b0};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INIT_CWND:     cfg_r.init_cwnd        <= cfg_wdata;
        REG_INIT_SSTHRESH: cfg_r.init_ssthresh    <= cfg_wdata;
        REG_BETA:          cfg_r.beta             <= cfg_wdata;
        REG_LOW_SEGS:      cfg_r.low_segs         <= cfg_wdata;
        REG_STEP_CAP:      cfg_r.step_cap         <= cfg_wdata;
        REG_RESET_INIT:    cfg_r.reset_to_initial <= cfg_wdata[0];
        REG_DISABLE_CWA:   cfg_r.disable_cwa      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_tready = rst_n && !busy;

  bic_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready),
    .out_free(!ov_r || out_tready), .sts(sts), .cmd(cmd), .busy(busy)
  );

  bic_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .cmd(cmd), .sts(sts),
    .in_action(in_tuser), .in_seg(in_tdata[31:0]), .in_hreq(in_tdata[63:32]),
    .win(win), .thr(thr), .reacted(reacted)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.out_load) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
    if (cmd.out_load) begin
      out_tdata <= {thr, win};
      out_tuser <= reacted;
    end
  end

  assign out_tvalid = ov_r;

endmodule

@@ hdl/bic_divider.sv @@
module bic_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [bic_pkg::QW-1:0] num,
  input  logic [bic_pkg::QW-1:0] den,
  output logic                  done,
  output logic [bic_pkg::QW-1:0] quo
);
  import bic_pkg::*;

  logic [DIV_BITS-1:0] n_r, n_nxt;
  logic [QW:0]         rem_r, rem_nxt;
  logic [QW-1:0]       d_r;
  logic [DIV_CW-1:0]   cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                zero_r;
  logic [QW+1:0]       trial;

  always_comb begin
    trial    = {rem_r, n_r[DIV_BITS-1]} - {2'b00, d_r};
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      n_nxt    = {num, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      cnt_nxt  = DIV_CW'(DIV_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[QW+1]) begin
        rem_nxt = trial[QW:0];
        n_nxt   = {n_r[DIV_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[QW-1:0], n_r[DIV_BITS-1]};
        n_nxt   = {n_r[DIV_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DIV_CW'(1);
      if (cnt_r == DIV_CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      d_r    <= den;
      zero_r <= (den == '0);
    end
  end

  assign done = !busy_r;
  assign quo  = (zero_r || n_r[DIV_BITS-1:QW] != '0) ? WMAX : n_r[QW-1:0];

endmodule

@@ hdl/bic_datapath.sv @@
module bic_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bic_pkg::cfg_t         cfg,
  input  bic_pkg::cmd_t         cmd,
  output bic_pkg::sts_t         sts,
  input  logic                  in_action,
  input  logic [31:0]           in_seg,
  input  logic [31:0]           in_hreq,
  output logic [31:0]           win,
  output logic [31:0]           thr,
  output logic                  reacted
);
  import bic_pkg::*;

  logic [QW-1:0] cwnd_r, ssth_r, maxw_r, minw_r, tgt_r, pstep_r, ptgt_r;
  logic          probing_r, act_r, react_r;
  logic [SEG_BITS-1:0] hseg_r, rp_r, hreq_r;
  logic [QW-1:0] num_r, prod_hi_r, quo;
  logic          need_div_r, dec_mode_r, done;
  logic [QW-1:0] low_q, inc_q;
  logic [QW+16:0] prod;

  assign low_q = to_q(cfg.low_segs);
  assign inc_q = to_q(cfg.step_cap);

  bic_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(num_r), .den(cwnd_r), .done(done), .quo(quo)
  );

  always_ff @(posedge clk) begin
    logic [QW-1:0] c, d, mx, ps, pt;
    logic [QW:0]   s;
    if (!rst_n) begin
      cwnd_r    <= QONE;
      ssth_r    <= to_q(16'hFFFF);
      maxw_r    <= WMAX;
      minw_r    <= '0;
      tgt_r     <= '0;
      probing_r <= 1'b0;
      pstep_r   <= '0;
      ptgt_r    <= '0;
      hseg_r    <= '0;
      rp_r      <= '0;
      react_r   <= 1'b0;
      act_r     <= 1'b0;
    end else begin
      if (cmd.load) begin
        act_r  <= in_action;
        hreq_r <= SEG_BITS'(in_hreq);
        if (!in_action && SEG_BITS'(in_seg) > hseg_r) hseg_r <= SEG_BITS'(in_seg);
      end
      if (cmd.prep) begin
        need_div_r <= !act_r && !(cwnd_r < low_q && cwnd_r <= ssth_r);
        dec_mode_r <= !act_r && cwnd_r >= low_q && !probing_r && tgt_r < cwnd_r;
        react_r    <= act_r && sts.react;
        if (!act_r) begin
          if (cwnd_r < low_q) begin
            num_r <= QONE;
          end else if (!probing_r) begin
            if (tgt_r >= cwnd_r) begin
              num_r <= ((tgt_r - cwnd_r) < inc_q) ? tgt_r - cwnd_r : inc_q;
            end else begin
              num_r <= cwnd_r - tgt_r;
            end
          end else begin
            num_r <= pstep_r;
          end
        end else if (sts.react) begin
          rp_r <= hreq_r;
        end
      end
      if (cmd.mul) prod_hi_r <= prod[QW+15:16];
      if (cmd.apply) begin
        c = cwnd_r; mx = maxw_r; ps = pstep_r; pt = ptgt_r;
        if (!act_r) begin
          if (cwnd_r < low_q) begin
            s = {1'b0, c} + {1'b0, (need_div_r ? quo : QONE)};
            cwnd_r <= sat_q(s);
          end else if (!probing_r) begin
            if (!dec_mode_r) c = sat_q({1'b0, c} + {1'b0, quo});
            else c = (quo <= c) ? c - quo : '0;
            cwnd_r <= c;
            d = mx - c;
            if (mx > c && d > DIFF_FLOOR) begin
              minw_r <= c;
              s = {1'b0, mx} + {1'b0, c};
              tgt_r <= s[QW:1];
            end else begin
              probing_r <= 1'b1;
              pstep_r   <= QONE;
              ptgt_r    <= sat_q({1'b0, c} + {1'b0, QONE});
              maxw_r    <= WMAX;
            end
          end else begin
            c = sat_q({1'b0, c} + {1'b0, quo});
            cwnd_r <= c;
            if (c >= pt) begin
              ps = ps[QW-1] ? WMAX : {ps[QW-2:0], 1'b0};
              pt = sat_q({1'b0, c} + {1'b0, ps});
            end
            pstep_r <= ps;
            ptgt_r  <= pt;
            if (ps >= inc_q) probing_r <= 1'b0;
          end
        end else if (react_r) begin
          if (cwnd_r >= low_q) begin
            mx = cwnd_r;
            c  = prod_hi_r;
            if (maxw_r > mx) begin
              s  = {1'b0, mx} + {1'b0, c};
              mx = s[QW:1];
            end
            s = {1'b0, mx} + {1'b0, c};
            maxw_r <= mx;
            minw_r <= c;
            tgt_r  <= s[QW:1];
          end else begin
            c = {1'b0, cwnd_r[QW-1:1]};
          end
          if (cfg.reset_to_initial) begin
            ssth_r <= {1'b0, c[QW-1:1]};
            cwnd_r <= to_q(cfg.init_cwnd);
          end else begin
            if (cwnd_r < low_q) ssth_r <= c;
            cwnd_r <= c;
          end
        end
      end
    end
  end

  assign prod = {17'd0, cwnd_r} * {{(QW+1){1'b0}}, cfg.beta};

  assign sts.is_loss  = act_r;
  assign sts.react    = cfg.disable_cwa || (hseg_r > rp_r);
  assign sts.need_div = need_div_r;
  assign sts.div_done = done;

  assign win     = cwnd_r;
  assign thr     = ssth_r;
  assign reacted = react_r;

endmodule

@@ hdl/bic_ctrl.sv @@
module bic_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          out_free,
  input  bic_pkg::sts_t sts,
  output bic_pkg::cmd_t cmd,
  output logic          busy
);
  import bic_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.is_loss ? ST_MUL : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_start = sts.need_div;
        state_nxt     = ST_APPLY;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (sts.div_done) begin
          cmd.apply = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == ST_IDLE) else $error("load outside idle");
  a_apply_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> sts.div_done) else $error("apply before divide done");
  a_prep_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_PREP) else $error("no prep after load");

endmodule
